### hw/rtl/kqt_pkg.sv
// kqt_pkg: shared types, codes and helpers for the keyed quantity table.
// Used by the channel interfaces, the sequencer, the store and the top level.
package kqt_pkg;

    localparam int OP_W   = 2;
    localparam int KEY_W  = 32;
    localparam int QTY_W  = 32;
    localparam int ST_W   = 2;
    localparam int ECNT_W = 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_EXISTS    = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

    localparam logic signed [QTY_W-1:0] QTY_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [QTY_W-1:0] QTY_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [ST_W-1:0]          status;
        logic signed [QTY_W-1:0]  quantity;
        logic [ECNT_W-1:0]        entry_count;
    } t_rsp;

    // Write strobe and data toward the store; address travels beside it.
    typedef struct packed {
        logic                     key_en;
        logic                     qty_en;
        logic [KEY_W-1:0]         key;
        logic signed [QTY_W-1:0]  qty;
    } t_wr;

    // Signed add clamped to the 32-bit signed range.
    function automatic logic signed [QTY_W-1:0] sat_add(
        input logic signed [QTY_W-1:0] a,
        input logic signed [QTY_W-1:0] b
    );
        logic signed [QTY_W:0] sum;
        logic signed [QTY_W-1:0] res;
        sum = {a[QTY_W-1], a} + {b[QTY_W-1], b};
        if (sum[QTY_W] != sum[QTY_W-1]) begin
            res = sum[QTY_W] ? QTY_MIN : QTY_MAX;
        end else begin
            res = sum[QTY_W-1:0];
        end
        return res;
    endfunction

endpackage

### hw/rtl/kqt_if.sv
// Request and response channel interfaces (valid/ready) for the table.
// Depends on kqt_pkg for field widths.
interface kqt_req_if;
    import kqt_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         operation;
    logic [KEY_W-1:0]        part_key;
    logic signed [QTY_W-1:0] amount;

    modport source (output valid, output operation, output part_key, output amount,
                    input ready);
    modport sink   (input valid, input operation, input part_key, input amount,
                    output ready);
endinterface

interface kqt_rsp_if;
    import kqt_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [ST_W-1:0]         status;
    logic signed [QTY_W-1:0] quantity;
    logic [ECNT_W-1:0]       entry_count;

    modport source (output valid, output status, output quantity, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input quantity, input entry_count,
                    output ready);
endinterface

### hw/rtl/keyed_quantity_table_core.sv
// keyed_quantity_table_core: top level of the keyed quantity table.
// Depends on kqt_pkg, kqt_if (channels), kqt_store and kqt_ctrl.
//
// A table of up to MAX_ENTRIES unique 32-bit keys, each with a signed 32-bit
// quantity. A request transaction carries an operation (insert, search or
// update by delta), a key and an amount; each one yields exactly one response
// transaction with a status, the resulting quantity (zero unless status is
// ok) and the number of entries held afterwards (low 8 bits). Keys and
// quantities live in two single-port-read synchronous memories; lookup is a
// linear scan of the filled entries, one memory read per cycle. After
// acceptance a request issues the first read, compares the filled entries
// in order until the key is found (all of them on a miss), loads the
// response register and then hands the response over. Insert into a full
// table, insert into an empty table, operation code 3, and search or update
// of an empty table skip the scan and go straight to the response register.
// One request is in flight at a time; the response register lets the next
// request be accepted while the previous response still waits on a stalled
// sink. Updates saturate at the signed 32-bit limits. No clearing pass:
// entries above the fill count are never read, so the memories need no
// initialization after reset.
module keyed_quantity_table_core #(
    parameter int MAX_ENTRIES = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kqt_req_if.sink   i_req,
    kqt_rsp_if.source o_rsp
);
    import kqt_pkg::*;

    // Address indexes a slot; the count must also hold MAX_ENTRIES itself.
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic [KEY_W-1:0]        rd_key;
    logic signed [QTY_W-1:0] rd_qty;
    logic [AW-1:0]           wr_addr;
    t_wr                     wr;

    // Sequencer: scan, decision, write-back and response register
    kqt_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_key  (rd_key),
        .i_rd_qty  (rd_qty),
        .o_wr_addr (wr_addr),
        .o_wr      (wr)
    );

    // Key and quantity memories, read at the scan pointer
    kqt_store #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_key  (rd_key),
        .o_rd_qty  (rd_qty),
        .i_wr_addr (wr_addr),
        .i_wr      (wr)
    );

endmodule

### hw/rtl/kqt_store.sv
// kqt_store: key and quantity memories, one read port and one write port each,
// registered read data. Depends on kqt_pkg (t_wr).
module kqt_store #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic                            i_clk,
    input  logic                            i_rd_en,
    input  logic [AW-1:0]                   i_rd_addr,
    output logic [kqt_pkg::KEY_W-1:0]       o_rd_key,
    output logic signed [kqt_pkg::QTY_W-1:0] o_rd_qty,
    input  logic [AW-1:0]                   i_wr_addr,
    input  kqt_pkg::t_wr                    i_wr
);
    import kqt_pkg::*;

    logic [KEY_W-1:0]        key_mem [DEPTH];
    logic signed [QTY_W-1:0] qty_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr.key_en) begin
            key_mem[i_wr_addr] <= i_wr.key;
        end
        if (i_rd_en) begin
            o_rd_key <= key_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.qty_en) begin
            qty_mem[i_wr_addr] <= i_wr.qty;
        end
        if (i_rd_en) begin
            o_rd_qty <= qty_mem[i_rd_addr];
        end
    end

endmodule

### hw/rtl/kqt_ctrl.sv
// kqt_ctrl: per-transaction sequencer; scans the key store, decides status,
// issues the write-back and holds the response register. Depends on kqt_pkg.
module kqt_ctrl #(
    parameter int MAX_ENTRIES = 128,
    parameter int AW          = 7,
    parameter int CW          = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    kqt_req_if.sink                          i_req,
    kqt_rsp_if.source                        o_rsp,
    output logic                             o_rd_en,
    output logic [AW-1:0]                    o_rd_addr,
    input  logic [kqt_pkg::KEY_W-1:0]        i_rd_key,
    input  logic signed [kqt_pkg::QTY_W-1:0] i_rd_qty,
    output logic [AW-1:0]                    o_wr_addr,
    output kqt_pkg::t_wr                     o_wr
);
    import kqt_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_OUT} t_state;

    t_state                  r_state;
    logic [OP_W-1:0]         r_op;
    logic [KEY_W-1:0]        r_key;
    logic signed [QTY_W-1:0] r_amt;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           r_idx;
    logic                    r_cmp_vld;
    logic [AW-1:0]           r_cmp_idx;
    t_rsp                    r_res;
    t_rsp                    r_rsp;
    logic                    r_rsp_vld;
    logic [AW-1:0]           r_wr_addr;
    t_wr                     r_wr;

    logic                    accept;
    logic                    hit;
    logic                    last;
    logic                    out_free;
    logic [CW-1:0]           n_count;
    logic signed [QTY_W-1:0] upd_qty;

    assign accept   = i_req.valid && i_req.ready;
    assign hit      = r_cmp_vld && (i_rd_key == r_key);
    assign last     = r_cmp_vld && (CW'(r_cmp_idx) == r_count - CW'(1));
    assign out_free = !r_rsp_vld || o_rsp.ready;
    assign n_count  = r_count + CW'(1);
    assign upd_qty  = sat_add(i_rd_qty, r_amt);

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rd_en     = (r_state == S_SCAN) && (r_idx < r_count);
    assign o_rd_addr   = r_idx[AW-1:0];
    assign o_wr_addr   = r_wr_addr;
    assign o_wr        = r_wr;

    assign o_rsp.valid       = r_rsp_vld;
    assign o_rsp.status      = r_rsp.status;
    assign o_rsp.quantity    = r_rsp.quantity;
    assign o_rsp.entry_count = r_rsp.entry_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_rsp_vld <= 1'b0;
            r_wr      <= '0;
        end else begin
            r_wr.key_en <= 1'b0;
            r_wr.qty_en <= 1'b0;
            if (r_rsp_vld && o_rsp.ready) begin
                r_rsp_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op      <= i_req.operation;
                        r_key     <= i_req.part_key;
                        r_amt     <= i_req.amount;
                        r_idx     <= '0;
                        r_cmp_vld <= 1'b0;
                        r_res     <= '{ST_NOT_FOUND, '0, ECNT_W'(r_count)};
                        r_state   <= S_OUT;
                        if (i_req.operation == OP_INSERT) begin
                            if (r_count >= CW'(MAX_ENTRIES)) begin
                                r_res.status <= ST_FULL;
                            end else if (r_count == '0) begin
                                // Empty table: no scan needed
                                r_wr_addr <= '0;
                                r_wr      <= '{1'b1, 1'b1, i_req.part_key, i_req.amount};
                                r_count   <= n_count;
                                r_res     <= '{ST_OK, i_req.amount, ECNT_W'(n_count)};
                            end else begin
                                r_state <= S_SCAN;
                            end
                        end else if ((i_req.operation == OP_SEARCH ||
                                      i_req.operation == OP_UPDATE) && r_count != '0) begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_cmp_vld <= o_rd_en;
                    r_cmp_idx <= r_idx[AW-1:0];
                    if (o_rd_en) begin
                        r_idx <= r_idx + CW'(1);
                    end
                    if (hit || last) begin
                        r_cmp_vld <= 1'b0;
                        r_state   <= S_OUT;
                    end
                    if (hit) begin
                        case (r_op)
                            OP_INSERT: r_res.status <= ST_EXISTS;
                            OP_SEARCH: r_res <= '{ST_OK, i_rd_qty, ECNT_W'(r_count)};
                            default: begin
                                r_wr_addr <= r_cmp_idx;
                                r_wr      <= '{1'b0, 1'b1, r_key, upd_qty};
                                r_res     <= '{ST_OK, upd_qty, ECNT_W'(r_count)};
                            end
                        endcase
                    end else if (last && r_op == OP_INSERT) begin
                        // Miss on insert: append at the fill point
                        r_wr_addr <= r_count[AW-1:0];
                        r_wr      <= '{1'b1, 1'b1, r_key, r_amt};
                        r_count   <= n_count;
                        r_res     <= '{ST_OK, r_amt, ECNT_W'(n_count)};
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_rsp     <= r_res;
                        r_rsp_vld <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Fill count never passes capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("fill count above capacity");

    // Write-back only lands while the result is being handed over
    a_wr_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr.key_en || r_wr.qty_en) |-> r_state == S_OUT)
        else $error("store write outside result state");

    // Compared entry is always a filled one
    a_cmp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> CW'(r_cmp_idx) < r_count)
        else $error("compare of unfilled entry");

    // Count grows by one, and only together with a key write
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_count != $past(r_count)) |->
            (r_count == $past(r_count) + CW'(1)) && r_wr.key_en)
        else $error("fill count changed without insert");

endmodule
